>>> rtl/cgf_pkg.sv
// Shared constants, codes, types and helpers of the cell grid engine.
`timescale 1ns / 1ps
package cgf_pkg;

  localparam int MAX_COLUMNS = 256;
  localparam int MAX_ROWS    = 128;
  localparam int COL_W       = $clog2(MAX_COLUMNS);
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int XC_W        = COL_W + 1;
  localparam int YC_W        = ROW_W + 1;
  localparam int GLYPH_W     = 21;
  localparam int STYLE_W     = 16;
  localparam int CELL_W      = GLYPH_W + STYLE_W;
  localparam int CELL_AW     = ROW_W + COL_W;

  localparam logic [GLYPH_W-1:0] SPACE_GLYPH = GLYPH_W'(32);

  localparam logic [2:0] CMD_FILL      = 3'd0;
  localparam logic [2:0] CMD_CLR_ALL   = 3'd1;
  localparam logic [2:0] CMD_CLR_ROW   = 3'd2;
  localparam logic [2:0] CMD_CLR_TOP   = 3'd3;
  localparam logic [2:0] CMD_CLR_BELOW = 3'd4;
  localparam logic [2:0] CMD_READ      = 3'd5;

  localparam logic [2:0] REG_CANVAS_WIDTH  = 3'd0;
  localparam logic [2:0] REG_CANVAS_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CLIP_LEFT     = 3'd2;
  localparam logic [2:0] REG_CLIP_TOP      = 3'd3;
  localparam logic [2:0] REG_CLIP_RIGHT    = 3'd4;
  localparam logic [2:0] REG_CLIP_BOTTOM   = 3'd5;
  localparam logic [2:0] REG_BLANK_GLYPH   = 3'd6;
  localparam logic [2:0] REG_BLANK_STYLE   = 3'd7;

  typedef logic signed [11:0] s12_t;

  // Walker status toward the sequencer
  typedef struct packed {
    logic [XC_W-1:0] x;
    logic [YC_W-1:0] y;
    logic            col_in;
    logic            row_last;
    logic            last;
  } wk_stat_t;

  // Row table control from the sequencer
  typedef struct packed {
    logic             clr_all;
    logic             clr_row;
    logic             wr;
    logic [ROW_W-1:0] addr;
    logic [COL_W-1:0] wdata;
  } rt_ctl_t;

  function automatic s12_t smax(input s12_t a, input s12_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic s12_t smin(input s12_t a, input s12_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

>>> rtl/cgf_cell_ram.sv
// Cell store: one write port, one read port with registered data.
`timescale 1ns / 1ps
module cgf_cell_ram
  import cgf_pkg::*;
(
  input  logic               clk,
  input  logic               we,
  input  logic [CELL_AW-1:0] waddr,
  input  logic [CELL_W-1:0]  wdata,
  input  logic [CELL_AW-1:0] raddr,
  output logic [CELL_W-1:0]  rdata
);

  logic [CELL_W-1:0] mem [MAX_ROWS*MAX_COLUMNS];
  logic [CELL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/cgf_row_table.sv
// Last used column of each row: memory plus per-row valid bits.
`timescale 1ns / 1ps
module cgf_row_table
  import cgf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  rt_ctl_t             ctl,
  output logic [COL_W-1:0]    rdata,
  output logic                rvalid,
  output logic [MAX_ROWS-1:0] row_valid
);

  logic [COL_W-1:0]    mem [MAX_ROWS];
  logic [MAX_ROWS-1:0] valid_r;
  logic [COL_W-1:0]    rdata_r;
  logic                rvalid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (ctl.clr_all) begin
      valid_r <= '0;
    end else begin
      if (ctl.clr_row) valid_r[ctl.addr] <= 1'b0;
      if (ctl.wr)      valid_r[ctl.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[ctl.addr] <= ctl.wdata;
    end
    rdata_r  <= mem[ctl.addr];
    rvalid_r <= valid_r[ctl.addr];
  end

  assign rdata     = rdata_r;
  assign rvalid    = rvalid_r;
  assign row_valid = valid_r;

endmodule

>>> rtl/cgf_walk.sv
// Rectangle walker: steps column by column, row by row over a region.
`timescale 1ns / 1ps
module cgf_walk
  import cgf_pkg::*;
(
  input  logic            clk,
  input  logic            load,
  input  logic            step,
  input  logic [XC_W-1:0] xs,
  input  logic [XC_W-1:0] xe,
  input  logic [YC_W-1:0] ys,
  input  logic [YC_W-1:0] ye,
  output wk_stat_t        stat
);

  logic [XC_W-1:0] x_r, xs_r, xe_r;
  logic [YC_W-1:0] y_r, ye_r;
  logic            row_last;

  // a row with no columns is still visited, with col_in low
  assign row_last = ({1'b0, x_r} + 1'b1) >= {1'b0, xe_r};

  always_ff @(posedge clk) begin
    if (load) begin
      x_r  <= xs;
      xs_r <= xs;
      xe_r <= xe;
      y_r  <= ys;
      ye_r <= ye;
    end else if (step) begin
      if (row_last) begin
        x_r <= xs_r;
        y_r <= y_r + 1'b1;
      end else begin
        x_r <= x_r + 1'b1;
      end
    end
  end

  assign stat.x        = x_r;
  assign stat.y        = y_r;
  assign stat.col_in   = x_r < xe_r;
  assign stat.row_last = row_last;
  assign stat.last     = row_last && (({1'b0, y_r} + 1'b1) >= {1'b0, ye_r});

endmodule

>>> rtl/cell_grid_fill_clear_engine_core.sv
// Top level of the cell grid engine: sequencer, config registers, status.
//
//  channel | ports                         | handshake
//  --------+-------------------------------+------------------------------
//  input   | start, busy, in_*             | transfer when start && !busy
//  result  | out_valid, out_*              | one-cycle strobe, no back-off
//  config  | cfg_we, cfg_index, cfg_wdata  | write when cfg_we
//
// An item runs setup, then walks the cells of its region, if any, through
// the single cell write port (fill rectangle or cleared rows times canvas
// width; a row of zero width is still visited), then for a visible fill
// updates the table entry of each row, or for a clear that needs it scans
// rows upward for the lowest content row, and then gives the result.
// Reset is synchronous; cells stay undefined until written, row state is
// cleared at once. Results cannot be stalled.
`timescale 1ns / 1ps
module cell_grid_fill_clear_engine_core
  import cgf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               in_command,
  input  logic signed [10:0]       in_rect_left,
  input  logic signed [10:0]       in_rect_top,
  input  logic signed [10:0]       in_rect_right,
  input  logic signed [10:0]       in_rect_bottom,
  input  logic [GLYPH_W-1:0]       in_glyph,
  input  logic [STYLE_W-1:0]       in_style_id,
  input  logic signed [10:0]       in_row_index,
  input  logic signed [10:0]       in_row_limit,
  input  logic signed [10:0]       in_column_index,
  output logic                     out_valid,
  output logic [GLYPH_W-1:0]       out_cell_glyph,
  output logic [STYLE_W-1:0]       out_cell_style,
  output logic signed [7:0]        out_lowest_content_row,
  output logic signed [8:0]        out_row_last_column,
  output logic [7:0]               out_damage_top,
  output logic [7:0]               out_damage_rows,
  output logic                     out_painted,
  input  logic                     cfg_we,
  input  logic [2:0]               cfg_index,
  input  logic [GLYPH_W-1:0]       cfg_wdata
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SETUP = 7'b0000010,
    S_CELLS = 7'b0000100,
    S_ROWS  = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  // config
  logic [8:0]         width_r, clip_left_r, clip_right_r;
  logic [7:0]         height_r, clip_top_r, clip_bottom_r;
  logic [GLYPH_W-1:0] blank_glyph_r;
  logic [STYLE_W-1:0] blank_style_r;

  // latched command
  logic [2:0]         cmd_r;
  logic [10:0]        rl_r, rt_r, rr_r, rb_r, ri_r, lim_r, ci_r;
  logic [GLYPH_W-1:0] glyph_r;
  logic [STYLE_W-1:0] style_r;

  // status
  logic signed [7:0]  cb_r, cb_nxt;
  logic [7:0]         dmg_top_r, dmg_top_nxt, dmg_rows_r, dmg_rows_nxt;
  logic               painted_r, painted_nxt;

  // sequencer working registers
  logic [CELL_W-1:0]  cell_wd_r, cell_wd_nxt;
  logic               blank_r, blank_nxt, rows_r, rows_nxt, scan_r, scan_nxt;
  logic signed [7:0]  scan_y_r, scan_y_nxt;
  logic [YC_W-1:0]    fy0_r, fy0_nxt, fy1_r, fy1_nxt;
  logic [XC_W-1:0]    fx1_r, fx1_nxt;
  logic               rd_ok_r, rd_ok_nxt, ri_ok_r, ri_ok_nxt;

  // datapath
  logic [XC_W-1:0]    w_eff;
  logic [YC_W-1:0]    h_eff;
  s12_t               w_s, h_s, ri_s, lim_s, ci_s, cb_s;
  s12_t               fx0, fx1, fy0, fy1, keep_s, bot_s, rows_s;
  logic               fill_ok, visible, ri_ok, ci_ok;
  logic [COL_W-1:0]   fx1_m1;

  wk_stat_t           wk;
  logic               wk_load, wk_step;
  logic [XC_W-1:0]    wk_xs, wk_xe;
  logic [YC_W-1:0]    wk_ys, wk_ye;

  rt_ctl_t            rt_ctl;
  logic [COL_W-1:0]   rt_q;
  logic               rt_qv;
  logic [MAX_ROWS-1:0] row_valid;

  logic               ram_we;
  logic [CELL_W-1:0]  ram_q;

  assign w_eff = (width_r > 9'(MAX_COLUMNS)) ? XC_W'(MAX_COLUMNS) : XC_W'(width_r);
  assign h_eff = (height_r > 8'(MAX_ROWS)) ? YC_W'(MAX_ROWS) : YC_W'(height_r);

  assign w_s   = s12_t'({1'b0, w_eff});
  assign h_s   = s12_t'({1'b0, h_eff});
  assign ri_s  = s12_t'($signed(ri_r));
  assign lim_s = s12_t'($signed(lim_r));
  assign ci_s  = s12_t'($signed(ci_r));
  assign cb_s  = s12_t'(cb_r);

  assign fx0 = smax(smax(s12_t'(0), s12_t'($signed(rl_r))), s12_t'({3'b0, clip_left_r}));
  assign fy0 = smax(smax(s12_t'(0), s12_t'($signed(rt_r))), s12_t'({4'b0, clip_top_r}));
  assign fx1 = smin(smin(w_s, s12_t'($signed(rr_r))), s12_t'({3'b0, clip_right_r}));
  assign fy1 = smin(smin(h_s, s12_t'($signed(rb_r))), s12_t'({4'b0, clip_bottom_r}));

  assign fill_ok = (fx0 < fx1) && (fy0 < fy1);
  assign visible = (glyph_r != SPACE_GLYPH) || (style_r != '0);
  assign ri_ok   = (ri_s >= 0) && (ri_s < h_s);
  assign ci_ok   = (ci_s >= 0) && (ci_s < w_s);
  assign keep_s  = smax(ri_s, s12_t'(0));
  assign bot_s   = smin(h_s, lim_s);
  assign rows_s  = smin(ri_s, h_s);
  assign fx1_m1  = COL_W'(fx1_r - 1'b1);

  always_comb begin
    state_nxt    = state_r;
    cb_nxt       = cb_r;
    dmg_top_nxt  = dmg_top_r;
    dmg_rows_nxt = dmg_rows_r;
    painted_nxt  = painted_r;
    cell_wd_nxt  = cell_wd_r;
    blank_nxt    = blank_r;
    rows_nxt     = rows_r;
    scan_nxt     = scan_r;
    scan_y_nxt   = scan_y_r;
    fy0_nxt      = fy0_r;
    fy1_nxt      = fy1_r;
    fx1_nxt      = fx1_r;
    rd_ok_nxt    = rd_ok_r;
    ri_ok_nxt    = ri_ok_r;
    wk_load      = 1'b0;
    wk_step      = 1'b0;
    wk_xs        = '0;
    wk_xe        = w_eff;
    wk_ys        = '0;
    wk_ye        = '0;
    ram_we       = 1'b0;
    rt_ctl       = '0;
    rt_ctl.addr  = wk.y[ROW_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_SETUP;
      end

      S_SETUP: begin
        blank_nxt   = 1'b0;
        rows_nxt    = 1'b0;
        scan_nxt    = 1'b0;
        cell_wd_nxt = {blank_style_r, blank_glyph_r};
        wk_load     = 1'b1;
        case (cmd_r)
          CMD_FILL: begin
            if (fill_ok) begin
              cell_wd_nxt = {style_r, glyph_r};
              wk_xs       = XC_W'(fx0);
              wk_xe       = XC_W'(fx1);
              wk_ys       = YC_W'(fy0);
              wk_ye       = YC_W'(fy1);
              fy0_nxt     = YC_W'(fy0);
              fy1_nxt     = YC_W'(fy1);
              fx1_nxt     = XC_W'(fx1);
              painted_nxt = 1'b1;
              if (visible) begin
                rows_nxt = 1'b1;
                if ((fy1 - 1) > cb_s) cb_nxt = 8'(fy1 - 1);
              end
            end
          end
          CMD_CLR_ALL: begin
            rt_ctl.clr_all = 1'b1;
            blank_nxt      = 1'b1;
            wk_ye          = h_eff;
            dmg_top_nxt    = '0;
            dmg_rows_nxt   = 8'(h_eff);
            cb_nxt         = -8'sd1;
            painted_nxt    = 1'b0;
          end
          CMD_CLR_ROW: begin
            if (ri_ok) begin
              blank_nxt = 1'b1;
              wk_ys     = YC_W'(ri_s);
              wk_ye     = YC_W'(ri_s + 1);
              if (ri_s == cb_s) begin
                scan_nxt   = 1'b1;
                scan_y_nxt = 8'(ri_s - 1);
              end
            end
          end
          CMD_CLR_TOP: begin
            if (ri_s > 0) begin
              blank_nxt    = 1'b1;
              wk_ye        = YC_W'(rows_s);
              dmg_top_nxt  = '0;
              dmg_rows_nxt = 8'(rows_s);
              scan_nxt     = 1'b1;
              scan_y_nxt   = 8'(h_s - 1);
              painted_nxt  = 1'b0;
            end
          end
          CMD_CLR_BELOW: begin
            if ((ri_s <= 0) && (lim_s >= h_s)) begin
              rt_ctl.clr_all = 1'b1;
              blank_nxt      = 1'b1;
              wk_ye          = h_eff;
              dmg_top_nxt    = '0;
              dmg_rows_nxt   = 8'(h_eff);
              cb_nxt         = -8'sd1;
              painted_nxt    = 1'b0;
            end else if (ri_s < h_s) begin
              if (bot_s > keep_s) begin
                blank_nxt    = 1'b1;
                wk_ys        = YC_W'(keep_s);
                wk_ye        = YC_W'(bot_s);
                dmg_rows_nxt = 8'(bot_s - keep_s);
              end else begin
                dmg_rows_nxt = '0;
              end
              scan_nxt    = 1'b1;
              scan_y_nxt  = 8'(keep_s - 1);
              dmg_top_nxt = 8'(keep_s);
              painted_nxt = 1'b0;
            end
          end
          default: ;
        endcase
        // walk only when a region was planned and it has rows
        if ((blank_nxt || (cmd_r == CMD_FILL && fill_ok)) && (wk_ys < wk_ye)) begin
          state_nxt = S_CELLS;
        end else if (scan_nxt) begin
          state_nxt = S_SCAN;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_CELLS: begin
        ram_we         = wk.col_in;
        rt_ctl.clr_row = blank_r;
        wk_step        = 1'b1;
        if (wk.last) begin
          if (rows_r) begin
            // second pass: column 0 reads the row entry, column 1 writes it
            wk_load   = 1'b1;
            wk_xs     = '0;
            wk_xe     = XC_W'(2);
            wk_ys     = fy0_r;
            wk_ye     = fy1_r;
            state_nxt = S_ROWS;
          end else if (scan_r) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end

      S_ROWS: begin
        wk_step = 1'b1;
        if (wk.x[0]) begin
          rt_ctl.wr    = 1'b1;
          rt_ctl.wdata = (rt_qv && (rt_q > fx1_m1)) ? rt_q : fx1_m1;
        end
        if (wk.last) state_nxt = S_FIN;
      end

      S_SCAN: begin
        if (scan_y_r < 0) begin
          cb_nxt    = -8'sd1;
          state_nxt = S_FIN;
        end else if (row_valid[scan_y_r[ROW_W-1:0]]) begin
          cb_nxt    = scan_y_r;
          state_nxt = S_FIN;
        end else begin
          scan_y_nxt = scan_y_r - 8'sd1;
        end
      end

      S_FIN: begin
        rt_ctl.addr = ri_r[ROW_W-1:0];
        rd_ok_nxt   = (cmd_r == CMD_READ) && ri_ok && ci_ok;
        ri_ok_nxt   = ri_ok;
        state_nxt   = S_OUT;
      end

      S_OUT: begin
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cb_r       <= -8'sd1;
      dmg_top_r  <= '0;
      dmg_rows_r <= 8'd24;
      painted_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cb_r       <= cb_nxt;
      dmg_top_r  <= dmg_top_nxt;
      dmg_rows_r <= dmg_rows_nxt;
      painted_r  <= painted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r       <= 9'd80;
      height_r      <= 8'd24;
      clip_left_r   <= '0;
      clip_top_r    <= '0;
      clip_right_r  <= 9'd256;
      clip_bottom_r <= 8'd128;
      blank_glyph_r <= SPACE_GLYPH;
      blank_style_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CANVAS_WIDTH:  width_r       <= cfg_wdata[8:0];
        REG_CANVAS_HEIGHT: height_r      <= cfg_wdata[7:0];
        REG_CLIP_LEFT:     clip_left_r   <= cfg_wdata[8:0];
        REG_CLIP_TOP:      clip_top_r    <= cfg_wdata[7:0];
        REG_CLIP_RIGHT:    clip_right_r  <= cfg_wdata[8:0];
        REG_CLIP_BOTTOM:   clip_bottom_r <= cfg_wdata[7:0];
        REG_BLANK_GLYPH:   blank_glyph_r <= cfg_wdata;
        REG_BLANK_STYLE:   blank_style_r <= cfg_wdata[STYLE_W-1:0];
        default: ;
      endcase
    end
  end

  // payload and working registers, no reset needed
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      cmd_r   <= in_command;
      rl_r    <= in_rect_left;
      rt_r    <= in_rect_top;
      rr_r    <= in_rect_right;
      rb_r    <= in_rect_bottom;
      glyph_r <= in_glyph;
      style_r <= in_style_id;
      ri_r    <= in_row_index;
      lim_r   <= in_row_limit;
      ci_r    <= in_column_index;
    end
    cell_wd_r <= cell_wd_nxt;
    blank_r   <= blank_nxt;
    rows_r    <= rows_nxt;
    scan_r    <= scan_nxt;
    scan_y_r  <= scan_y_nxt;
    fy0_r     <= fy0_nxt;
    fy1_r     <= fy1_nxt;
    fx1_r     <= fx1_nxt;
    rd_ok_r   <= rd_ok_nxt;
    ri_ok_r   <= ri_ok_nxt;
  end

  cgf_walk u_walk (
    .clk   (clk),
    .load  (wk_load),
    .step  (wk_step),
    .xs    (wk_xs),
    .xe    (wk_xe),
    .ys    (wk_ys),
    .ye    (wk_ye),
    .stat  (wk)
  );

  cgf_cell_ram u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({wk.y[ROW_W-1:0], wk.x[COL_W-1:0]}),
    .wdata (cell_wd_r),
    .raddr ({ri_r[ROW_W-1:0], ci_r[COL_W-1:0]}),
    .rdata (ram_q)
  );

  cgf_row_table u_rows (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (rt_ctl),
    .rdata     (rt_q),
    .rvalid    (rt_qv),
    .row_valid (row_valid)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  assign out_cell_glyph         = rd_ok_r ? ram_q[GLYPH_W-1:0] : '0;
  assign out_cell_style         = rd_ok_r ? ram_q[CELL_W-1:GLYPH_W] : '0;
  assign out_lowest_content_row = cb_r;
  assign out_row_last_column    = (ri_ok_r && rt_qv) ? $signed({1'b0, rt_q}) : -9'sd1;
  assign out_damage_top         = dmg_top_r;
  assign out_damage_rows        = dmg_rows_r;
  assign out_painted            = painted_r;

endmodule

>>> rtl/cgf_checker.sv
// Port-level checks of the cell grid engine, bound to the top level.
`timescale 1ns / 1ps
module cgf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input logic [7:0]        out_damage_rows,
  input logic signed [7:0] out_lowest_content_row
);

  // an accepted transfer raises busy; a result comes only while busy and is followed by idle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted command did not raise busy");

  a_result_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result outside a command");

  a_result_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe not followed by idle");

  a_band_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_damage_rows <= 8'd128) && (out_lowest_content_row >= -8'sd1))
    else $error("status out of range");

endmodule

bind cell_grid_fill_clear_engine_core cgf_checker u_cgf_checker (.*);
